### sv/assert_macros.svh
// Assertion helpers included by the top-level RTL file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold at every rising edge outside reset.
`define ASSERT_AT(lbl, clk, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Condition must never be seen at a rising edge outside reset.
`define ASSERT_NEVER(lbl, clk, rst_n, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`endif

### sv/isr_pkg.sv
package isr_pkg;

	// One stored stack word.
	typedef logic signed [31:0] word_t;

	// Request kinds.
	localparam logic [1:0] OP_PUSH = 2'd0;
	localparam logic [1:0] OP_POP  = 2'd1;
	localparam logic [1:0] OP_ROLL = 2'd2;

	// Result status codes.
	localparam logic [1:0] STAT_OK      = 2'd0;
	localparam logic [1:0] STAT_EMPTY   = 2'd1;
	localparam logic [1:0] STAT_BAD_POS = 2'd2;
	localparam logic [1:0] STAT_FULL    = 2'd3;

	// What a cell loads at the next edge. Up is toward the top of the stack.
	typedef enum logic [1:0] {
		CMD_HOLD,
		CMD_FROM_UP,
		CMD_FROM_DOWN
	} cell_cmd_t;

	// Controller states.
	typedef enum logic {
		S_IDLE,
		S_ROLL
	} state_t;

	typedef struct packed {
		logic [1:0] op;
		word_t      push_value;
		logic [4:0] position;
	} req_beat_t;

	typedef struct packed {
		word_t      popped_value;
		logic [1:0] status;
		logic       is_empty;
	} rsp_beat_t;

endpackage

### sv/int_stack_with_roll_top.sv
// Bounded LIFO stack of signed 32-bit words with push, pop and roll-to-top.
// Requests arrive on the req channel (req_valid, req_stall, req) and every
// request returns exactly one beat on the rsp channel (rsp_valid, rsp_stall,
// rsp) carrying the popped word, a status code and the empty flag.
// The words sit in a chain of STACK_DEPTH cells with the top in cell 0; push
// and pop shift every cell of the chain by one place together.
// Push, pop, rejected requests and rolls at depth 0 or 1 stay in S_IDLE: the
// response appears in the cycle after the request beat, and a new request can
// be taken every cycle while the receiver keeps up.
// A roll at depth p passes through S_ROLL: after the accepting edge the entry
// walks toward the top by one neighbor exchange per cycle, p - 1 exchanges in all.
// req_stall is high while a roll is under way.
// The response sits in an output register; while rsp_stall holds it there the
// block takes no new request, and it resumes as soon as that beat leaves.
// Reset empties the stack (count zero) and drops any pending response; the
// stored words are not cleared.
module int_stack_with_roll_top #(
	parameter int STACK_DEPTH = 16
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               req_valid,
	output logic               req_stall,
	input  isr_pkg::req_beat_t req,
	output logic               rsp_valid,
	input  logic               rsp_stall,
	output isr_pkg::rsp_beat_t rsp
);
	import isr_pkg::*;
	`include "assert_macros.svh"

	localparam int CW = $clog2(STACK_DEPTH + 1);
	localparam int KW = $clog2(STACK_DEPTH);
	localparam int AW = CW + 1;

	state_t          state_q, state_d;
	logic [CW-1:0]   count_q, count_d;
	logic [KW-1:0]   k_q, k_d;
	logic            rsp_valid_q;
	rsp_beat_t       rsp_q;
	logic            accept;
	logic            post;
	rsp_beat_t       post_beat;
	logic            full;
	logic            pos_bad;
	cell_cmd_t       cmd [STACK_DEPTH];
	word_t           cell_word [STACK_DEPTH];

	// The chain of cells; cell 0 is the top of the stack.
	for (genvar gi = 0; gi < STACK_DEPTH; gi++) begin : g_cell
		word_t up_word;
		word_t down_word;
		if (gi == 0) begin : g_top
			assign up_word = req.push_value;
		end else begin : g_mid_up
			assign up_word = cell_word[gi-1];
		end
		if (gi == STACK_DEPTH - 1) begin : g_bottom
			assign down_word = '0;
		end else begin : g_mid_down
			assign down_word = cell_word[gi+1];
		end
		isr_cell u_cell (
			.clk       (clk),
			.cmd       (cmd[gi]),
			.up_word   (up_word),
			.down_word (down_word),
			.word_q    (cell_word[gi])
		);
	end

	// Take a request only when idle and the output register is free or draining.
	assign req_stall = (state_q != S_IDLE) || (rsp_valid_q && rsp_stall);
	assign accept    = req_valid && !req_stall;
	assign full      = (count_q == CW'(STACK_DEPTH));
	assign pos_bad   = (32'(req.position) > 32'(count_q));

	// Next state, count, cell commands and the response to post.
	always_comb begin
		state_d   = state_q;
		count_d   = count_q;
		k_d       = k_q;
		post      = 1'b0;
		post_beat = '{popped_value: '0, status: STAT_OK, is_empty: (count_q == '0)};
		for (int i = 0; i < STACK_DEPTH; i++) begin
			cmd[i] = CMD_HOLD;
		end
		case (state_q)
			S_IDLE: begin
				if (accept) begin
					post = 1'b1;
					case (req.op)
						OP_PUSH: begin
							if (full) begin
								post_beat.status = STAT_FULL;
							end else begin
								for (int i = 0; i < STACK_DEPTH; i++) begin
									cmd[i] = CMD_FROM_UP;
								end
								count_d            = count_q + CW'(1);
								post_beat.is_empty = 1'b0;
							end
						end
						OP_POP: begin
							if (count_q == '0) begin
								post_beat.status = STAT_EMPTY;
							end else begin
								for (int i = 0; i < STACK_DEPTH; i++) begin
									cmd[i] = CMD_FROM_DOWN;
								end
								count_d                = count_q - CW'(1);
								post_beat.popped_value = cell_word[0];
								post_beat.is_empty     = (count_q == CW'(1));
							end
						end
						OP_ROLL: begin
							if (req.position > 5'd1) begin
								if (pos_bad) begin
									post_beat.status = STAT_BAD_POS;
								end else begin
									// Exchanges run from depth p-1/p up to the top.
									post    = 1'b0;
									state_d = S_ROLL;
									k_d     = KW'(32'(req.position) - 32'd2);
								end
							end
						end
						default: begin
						end
					endcase
				end
			end
			S_ROLL: begin
				// Exchange cells k and k+1, moving the rolled word one place up.
				for (int i = 0; i < STACK_DEPTH; i++) begin
					if (KW'(i) == k_q) begin
						cmd[i] = CMD_FROM_DOWN;
					end else if (i > 0 && KW'(i - 1) == k_q) begin
						cmd[i] = CMD_FROM_UP;
					end
				end
				if (k_q == '0) begin
					post    = 1'b1;
					state_d = S_IDLE;
				end else begin
					k_d = k_q - KW'(1);
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	// Control registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			count_q <= '0;
			k_q     <= '0;
		end else begin
			state_q <= state_d;
			count_q <= count_d;
			k_q     <= k_d;
		end
	end

	// Output register; a new beat is posted only when the slot is free or its beat is leaving.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (post) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp_valid_q && !rsp_stall) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (post) begin
			rsp_q <= post_beat;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	`ASSERT_AT(a_count_bound, clk, arst_n, count_q <= CW'(STACK_DEPTH), "entry count past depth")
	`ASSERT_AT(a_roll_in_range, clk, arst_n,
		(state_q == S_ROLL) |-> ((AW'(k_q) + AW'(1)) < AW'(count_q)), "roll index past count")
	`ASSERT_NEVER(a_post_over_full, clk, arst_n, post && rsp_valid_q && rsp_stall,
		"response posted over a held beat")
	`ASSERT_AT(a_roll_keeps_count, clk, arst_n,
		(state_q == S_ROLL) |=> $stable(count_q), "count changed during roll")

endmodule

### sv/isr_cell.sv
module isr_cell (
	input  logic              clk,
	input  isr_pkg::cell_cmd_t cmd,
	input  isr_pkg::word_t    up_word,
	input  isr_pkg::word_t    down_word,
	output isr_pkg::word_t    word_q
);
	import isr_pkg::*;

	// One stack slot: keep its word or take a neighbor's.
	always_ff @(posedge clk) begin
		case (cmd)
			CMD_FROM_UP:   word_q <= up_word;
			CMD_FROM_DOWN: word_q <= down_word;
			default:       word_q <= word_q;
		endcase
	end

endmodule

### verif/int_stack_with_roll_top_test.sv
`timescale 1ns / 1ps

module int_stack_with_roll_top_test;
	import isr_pkg::*;

	localparam int STACK_DEPTH = 16;
	// Op code 3 has no meaning; the block must ignore it.
	localparam logic [1:0] OP_UNUSED = 2'd3;
	localparam int RANDOM_BEATS = 530;
	localparam int CALM_TAIL = 80;
	localparam int PHASE_LEN = 40;

	// One row of the directed sequence. A row with reps > 1 repeats the request,
	// adding the repeat index to the value. Where fixed is set, the response is
	// the typed-in one; otherwise it comes from the stack mirror.
	typedef struct packed {
		logic [1:0] op;
		logic [31:0] value;
		logic [4:0] position;
		logic [4:0] reps;
		logic fixed;
		rsp_beat_t want;
	} dir_row_t;

	localparam int DIR_ROW_COUNT = 20;
	localparam dir_row_t DIRECTED [DIR_ROW_COUNT] = '{
		'{OP_POP, 32'h0, 5'd0, 5'd1, 1'b1, '{32'h0, STAT_EMPTY, 1'b1}},
		'{OP_ROLL, 32'h0, 5'd0, 5'd1, 1'b1, '{32'h0, STAT_OK, 1'b1}},
		'{OP_ROLL, 32'hFFFF_FFFF, 5'd1, 5'd1, 1'b1, '{32'h0, STAT_OK, 1'b1}},
		'{OP_ROLL, 32'h0, 5'd2, 5'd1, 1'b1, '{32'h0, STAT_BAD_POS, 1'b1}},
		'{OP_UNUSED, 32'h1234_5678, 5'd31, 5'd1, 1'b1, '{32'h0, STAT_OK, 1'b1}},
		'{OP_PUSH, 32'h7FFF_FFFF, 5'd0, 5'd1, 1'b1, '{32'h0, STAT_OK, 1'b0}},
		'{OP_POP, 32'h0, 5'd0, 5'd1, 1'b1, '{32'h7FFF_FFFF, STAT_OK, 1'b1}},
		'{OP_PUSH, 32'h8000_0000, 5'd31, 5'd1, 1'b1, '{32'h0, STAT_OK, 1'b0}},
		'{OP_POP, 32'hFFFF_FFFF, 5'd31, 5'd1, 1'b1, '{32'h8000_0000, STAT_OK, 1'b1}},
		'{OP_PUSH, 32'hFFFF_FFFF, 5'd0, 5'd1, 1'b0, '0},
		'{OP_PUSH, 32'h0000_0100, 5'd0, 5'd15, 1'b0, '0},
		'{OP_PUSH, 32'h0000_0005, 5'd0, 5'd1, 1'b1, '{32'h0, STAT_FULL, 1'b0}},
		'{OP_ROLL, 32'h0, 5'd16, 5'd1, 1'b0, '0},
		'{OP_ROLL, 32'h0, 5'd17, 5'd1, 1'b1, '{32'h0, STAT_BAD_POS, 1'b0}},
		'{OP_ROLL, 32'h0, 5'd31, 5'd1, 1'b1, '{32'h0, STAT_BAD_POS, 1'b0}},
		'{OP_ROLL, 32'h0, 5'd2, 5'd1, 1'b0, '0},
		'{OP_ROLL, 32'h0, 5'd8, 5'd1, 1'b0, '0},
		'{OP_UNUSED, 32'h0, 5'd0, 5'd1, 1'b1, '{32'h0, STAT_OK, 1'b0}},
		'{OP_POP, 32'h0, 5'd0, 5'd16, 1'b0, '0},
		'{OP_POP, 32'h0, 5'd0, 5'd1, 1'b1, '{32'h0, STAT_EMPTY, 1'b1}}
	};

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic req_valid = 1'b0;
	logic req_stall;
	req_beat_t req = '0;
	logic rsp_valid;
	logic rsp_stall = 1'b0;
	rsp_beat_t rsp;

	// Mirror of the stack contents; index 0 is the bottom.
	word_t held_words [STACK_DEPTH];
	int held_count = 0;

	rsp_beat_t awaited_rsps [$];
	rsp_beat_t oldest_rsp;
	int mismatch_count = 0;
	bit bursts_on = 1'b1;
	int stall_left = 0;

	int_stack_with_roll_top #(
		.STACK_DEPTH(STACK_DEPTH)
	) u_top (
		.clk(clk),
		.arst_n(arst_n),
		.req_valid(req_valid),
		.req_stall(req_stall),
		.req(req),
		.rsp_valid(rsp_valid),
		.rsp_stall(rsp_stall),
		.rsp(rsp)
	);

	always #2 clk = ~clk;

	// Applies one request to the mirror and returns the response it should give.
	function automatic rsp_beat_t stack_apply(req_beat_t b);
		rsp_beat_t r;
		int src;
		int i;
		word_t moved;
		r = '0;
		r.status = STAT_OK;
		case (b.op)
			OP_PUSH: begin
				if (held_count >= STACK_DEPTH) begin
					r.status = STAT_FULL;
				end else begin
					held_words[held_count] = b.push_value;
					held_count++;
				end
			end
			OP_POP: begin
				if (held_count == 0) begin
					r.status = STAT_EMPTY;
				end else begin
					held_count--;
					r.popped_value = held_words[held_count];
				end
			end
			OP_ROLL: begin
				if (b.position > 1) begin
					if (int'(b.position) > held_count) begin
						r.status = STAT_BAD_POS;
					end else begin
						src = held_count - int'(b.position);
						moved = held_words[src];
						for (i = src; i + 1 < held_count; i++) begin
							held_words[i] = held_words[i + 1];
						end
						held_words[held_count - 1] = moved;
					end
				end
			end
			default: begin
			end
		endcase
		r.is_empty = (held_count == 0);
		return r;
	endfunction

	// Random request shaped by the current fill level. Push-heavy phases drive the
	// stack toward full, the others toward empty; most rolls pick a position from 0 to one past the count.
	function automatic req_beat_t random_req(bit push_heavy);
		req_beat_t b;
		int pick;
		pick = $urandom_range(0, 99);
		b.push_value = $urandom();
		if ($urandom_range(0, 7) == 0) begin
			case ($urandom_range(0, 3))
				0: b.push_value = 32'h7FFF_FFFF;
				1: b.push_value = 32'h8000_0000;
				2: b.push_value = 32'h0;
				default: b.push_value = 32'hFFFF_FFFF;
			endcase
		end
		b.position = $urandom_range(0, 31);
		if (pick < (push_heavy ? 60 : 25)) begin
			b.op = OP_PUSH;
		end else if (pick < 75) begin
			b.op = OP_POP;
		end else if (pick < 95) begin
			b.op = OP_ROLL;
			if ($urandom_range(0, 4) != 0) begin
				b.position = $urandom_range(0, held_count + 1);
			end
		end else begin
			b.op = OP_UNUSED;
		end
		return b;
	endfunction

	// Drives one request beat, with an optional idle gap first, and records the
	// response it is owed once the beat is taken.
	task automatic send_req(input req_beat_t b, input bit fixed, input rsp_beat_t want);
		int gap;
		logic [63:0] junk;
		rsp_beat_t predicted;
		gap = 0;
		if (bursts_on && $urandom_range(0, 5) == 0) begin
			gap = $urandom_range(1, 16);
		end
		if (gap > 0) begin
			junk = {$urandom(), $urandom()};
			@(negedge clk);
			req_valid <= 1'b0;
			req <= junk[38:0];
			repeat (gap - 1) @(negedge clk);
		end
		@(negedge clk);
		req_valid <= 1'b1;
		req <= b;
		@(posedge clk);
		while (req_stall) @(posedge clk);
		predicted = stack_apply(b);
		awaited_rsps.push_back(fixed ? want : predicted);
	endtask

	// Response stall comes in random bursts while idling is enabled.
	always @(negedge clk) begin
		if (stall_left == 0 && bursts_on && $urandom_range(0, 5) == 0) begin
			stall_left = $urandom_range(1, 16);
		end
		if (stall_left > 0) begin
			rsp_stall <= 1'b1;
			stall_left--;
		end else begin
			rsp_stall <= 1'b0;
		end
	end

	// Every response beat taken is checked against the oldest one owed.
	always @(posedge clk) begin
		if (arst_n && rsp_valid && !rsp_stall) begin
			if (awaited_rsps.size() == 0) begin
				$display("%0t: unexpected response beat, expected none, actual %p", $time, rsp);
				mismatch_count++;
			end else begin
				oldest_rsp = awaited_rsps.pop_front();
				if (rsp.popped_value !== oldest_rsp.popped_value) begin
					$display("%0t: popped_value expected %0d, actual %0d", $time,
						oldest_rsp.popped_value, rsp.popped_value);
					mismatch_count++;
				end
				if (rsp.status !== oldest_rsp.status) begin
					$display("%0t: status expected %0d, actual %0d", $time,
						oldest_rsp.status, rsp.status);
					mismatch_count++;
				end
				if (rsp.is_empty !== oldest_rsp.is_empty) begin
					$display("%0t: is_empty expected %0b, actual %0b", $time,
						oldest_rsp.is_empty, rsp.is_empty);
					mismatch_count++;
				end
			end
		end
	end

	// Stimulus: reset, the directed rows, then random phases ending in a calm tail.
	initial begin
		req_beat_t b;
		bit push_heavy;
		push_heavy = 1'b0;
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		for (int k = 0; k < DIR_ROW_COUNT; k++) begin
			for (int j = 0; j < int'(DIRECTED[k].reps); j++) begin
				b.op = DIRECTED[k].op;
				b.push_value = DIRECTED[k].value + j;
				b.position = DIRECTED[k].position;
				send_req(b, DIRECTED[k].fixed, DIRECTED[k].want);
			end
		end

		for (int n = 0; n < RANDOM_BEATS; n++) begin
			if (n % PHASE_LEN == 0) begin
				push_heavy = !push_heavy;
				bursts_on = (n < RANDOM_BEATS - CALM_TAIL) && ($urandom_range(0, 3) != 0);
			end
			send_req(random_req(push_heavy), 1'b0, '0);
		end

		@(negedge clk);
		req_valid <= 1'b0;
		while (awaited_rsps.size() != 0) @(posedge clk);
		repeat (40) @(posedge clk);
		if (mismatch_count == 0) begin
			$display("PASS");
		end else begin
			$display("FAIL");
		end
		$finish;
	end

	// Hard stop in case the block hangs.
	initial begin
		#2_000_000;
		$display("FAIL");
		$finish;
	end

endmodule

### filelist.f
+incdir+sv
sv/isr_pkg.sv
sv/isr_cell.sv
sv/int_stack_with_roll_top.sv
verif/int_stack_with_roll_top_test.sv
